[rtl/core/dsten_pkg.sv]
package dsten_pkg;

	localparam int DEF_MAX_STEP   = 121;
	localparam int DEF_COORD_BITS = 12;

	// records one item may produce, and width of the per-item record counter
	localparam int MAX_RESULTS = 34;
	localparam int NREC_BITS   = $clog2(MAX_RESULTS);

	localparam int RTOT_BITS = 24;
	localparam int CTOT_BITS = 10;
	localparam logic [RTOT_BITS-1:0] REC_LIMIT   = RTOT_BITS'(9999999);
	localparam logic [CTOT_BITS-1:0] COLOR_LIMIT = CTOT_BITS'(999);

	localparam logic [7:0] BASE_B2   = 8'h03;
	localparam logic [7:0] JUMP_BIT  = 8'h80;
	localparam logic [7:0] COLOR_BIT = 8'h40;
	localparam logic [7:0] END_B2    = 8'hF3;

	localparam logic OP_STITCH = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam int NUM_DIGITS = 5;

	typedef struct packed {
		logic [6:0] weight;
		logic [5:0] thresh;
		logic [1:0] byte_sel;
		logic [7:0] xp;
		logic [7:0] xn;
		logic [7:0] yp;
		logic [7:0] yn;
	} digit_t;

	// balanced ternary digit table, most significant first
	function automatic digit_t digit_info(input logic [2:0] idx);
		digit_t d;
		case (idx)
			3'd0: d = '{7'd81, 6'd40, 2'd2, 8'h04, 8'h08, 8'h20, 8'h10};
			3'd1: d = '{7'd27, 6'd13, 2'd1, 8'h04, 8'h08, 8'h20, 8'h10};
			3'd2: d = '{7'd9,  6'd4,  2'd0, 8'h04, 8'h08, 8'h20, 8'h10};
			3'd3: d = '{7'd3,  6'd1,  2'd1, 8'h01, 8'h02, 8'h80, 8'h40};
			3'd4: d = '{7'd1,  6'd0,  2'd0, 8'h01, 8'h02, 8'h80, 8'h40};
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/dsten_in_if.sv]
interface dsten_in_if import dsten_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic                         jump;
	logic                         color_change;

	modport source (
		output valid, operation, pos_x, pos_y, jump, color_change,
		input  ready
	);
	modport sink (
		input  valid, operation, pos_x, pos_y, jump, color_change,
		output ready
	);
endinterface

[rtl/core/dsten_out_if.sv]
interface dsten_out_if import dsten_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) ();
	logic                  valid;
	logic                  ready;
	logic [7:0]            rec_b0;
	logic [7:0]            rec_b1;
	logic [7:0]            rec_b2;
	logic                  last;
	logic [RTOT_BITS-1:0]  record_total;
	logic [CTOT_BITS-1:0]  color_total;
	logic [COORD_BITS-2:0] plus_x;
	logic [COORD_BITS-1:0] minus_x;
	logic [COORD_BITS-2:0] plus_y;
	logic [COORD_BITS-1:0] minus_y;

	modport source (
		output valid, rec_b0, rec_b1, rec_b2, last, record_total, color_total,
		       plus_x, minus_x, plus_y, minus_y,
		input  ready
	);
	modport sink (
		input  valid, rec_b0, rec_b1, rec_b2, last, record_total, color_total,
		       plus_x, minus_x, plus_y, minus_y,
		output ready
	);
endinterface

[rtl/core/dsten_enc.sv]
// One move of at most +-121 per axis into the three record bytes.
module dsten_enc import dsten_pkg::*; (
	input  logic signed [7:0] step_x,
	input  logic signed [7:0] step_y,
	input  logic              jump,
	input  logic              color_change,
	output logic [7:0]        b0,
	output logic [7:0]        b1,
	output logic [7:0]        b2
);

	always_comb begin
		logic [2:0][7:0]   bytes;
		logic signed [8:0] rx;
		logic signed [8:0] ry;
		logic signed [8:0] w;
		logic signed [8:0] th;
		digit_t            d;
		bytes = '0;
		bytes[2] = BASE_B2 | (jump ? JUMP_BIT : 8'h00) | (color_change ? COLOR_BIT : 8'h00);
		rx = 9'(step_x);
		ry = 9'(step_y);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			d  = digit_info(3'(i));
			w  = $signed({2'b00, d.weight});
			th = $signed({3'b000, d.thresh});
			if (rx > th) begin
				bytes[d.byte_sel] = bytes[d.byte_sel] | d.xp;
				rx = rx - w;
			end else if (rx < -th) begin
				bytes[d.byte_sel] = bytes[d.byte_sel] | d.xn;
				rx = rx + w;
			end
			if (ry > th) begin
				bytes[d.byte_sel] = bytes[d.byte_sel] | d.yp;
				ry = ry - w;
			end else if (ry < -th) begin
				bytes[d.byte_sel] = bytes[d.byte_sel] | d.yn;
				ry = ry + w;
			end
		end
		b0 = bytes[0];
		b1 = bytes[1];
		b2 = bytes[2];
	end

endmodule

[rtl/core/dst_stitch_stream_encoder.sv]
// channel  | dir | transfers
// ---------+-----+----------------------------------------------------------
// stitch   | in  | operation, pos_x, pos_y, jump, color_change
// rec      | out | rec_b0..rec_b2, last, record_total, color_total, extents
//
// A stitch item is loaded, then emits its records one after another:
// 1 record for a move within +-MAX_STEP, up to 34 for a long move that is cut
// into jump records. A finish item emits one end record. The single record
// encoder builds every move record; the output register holds one record.
// Reset clears the position, extents and counters. A stalled rec channel
// holds the sequencer; stitch is taken only while the sequencer is idle.
module dst_stitch_stream_encoder import dsten_pkg::*; #(
	parameter int MAX_STEP   = DEF_MAX_STEP,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	dsten_in_if.sink     stitch,
	dsten_out_if.source  rec
);

	localparam int DW = COORD_BITS + 1;
	localparam logic signed [DW-1:0]        MAXS  = DW'(MAX_STEP);
	localparam logic [NREC_BITS-1:0]        NLAST = NREC_BITS'(MAX_RESULTS - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EMIT = 3'b010,
		S_END  = 3'b100
	} state_t;

	state_t                       state_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic signed [COORD_BITS-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [RTOT_BITS-1:0]         record_count_q;
	logic [CTOT_BITS-1:0]         color_count_q;
	logic signed [DW-1:0]         dx_q, dy_q;
	logic                         jmp_q, col_q;
	logic [NREC_BITS-1:0]         n_q;

	logic                  valid_q, last_q;
	logic [7:0]            b0_q, b1_q, b2_q;
	logic [RTOT_BITS-1:0]  rtot_q;
	logic [CTOT_BITS-1:0]  ctot_q;
	logic [COORD_BITS-2:0] plus_x_q, plus_y_q;
	logic [COORD_BITS-1:0] minus_x_q, minus_y_q;

	logic                  in_xfer, out_free, big, split, rec_load;
	logic signed [DW-1:0]  sx_w, sy_w;
	logic [7:0]            enc_b0, enc_b1, enc_b2;
	logic [RTOT_BITS-1:0]  rcount_inc;

	assign in_xfer  = stitch.valid && stitch.ready;
	assign out_free = !valid_q || rec.ready;
	assign stitch.ready = (state_q == S_IDLE);
	assign rec_load = out_free && (state_q == S_EMIT || state_q == S_END);

	assign big   = (dx_q > MAXS) || (dx_q < -MAXS) || (dy_q > MAXS) || (dy_q < -MAXS);
	assign split = big && (n_q < NLAST);

	assign sx_w = (dx_q > MAXS) ? MAXS : ((dx_q < -MAXS) ? -MAXS : dx_q);
	assign sy_w = (dy_q > MAXS) ? MAXS : ((dy_q < -MAXS) ? -MAXS : dy_q);

	assign rcount_inc = (record_count_q < REC_LIMIT) ? record_count_q + 1'b1
	                                                 : record_count_q;

	dsten_enc u_enc (
		.step_x       (sx_w[7:0]),
		.step_y       (sy_w[7:0]),
		.jump         (split ? 1'b1 : jmp_q),
		.color_change (split ? 1'b0 : col_q),
		.b0           (enc_b0),
		.b1           (enc_b1),
		.b2           (enc_b2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			min_x_q        <= '0;
			max_x_q        <= '0;
			min_y_q        <= '0;
			max_y_q        <= '0;
			record_count_q <= '0;
			color_count_q  <= '0;
			n_q            <= '0;
			valid_q        <= 1'b0;
		end else begin
			if (rec_load)
				valid_q <= 1'b1;
			else if (rec.ready)
				valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (stitch.operation == OP_FINISH) begin
							state_q <= S_END;
						end else begin
							state_q  <= S_EMIT;
							n_q      <= '0;
							prev_x_q <= stitch.pos_x;
							prev_y_q <= stitch.pos_y;
							if (stitch.pos_x < min_x_q) min_x_q <= stitch.pos_x;
							if (stitch.pos_x > max_x_q) max_x_q <= stitch.pos_x;
							if (stitch.pos_y < min_y_q) min_y_q <= stitch.pos_y;
							if (stitch.pos_y > max_y_q) max_y_q <= stitch.pos_y;
							if (stitch.color_change && color_count_q < COLOR_LIMIT)
								color_count_q <= color_count_q + 1'b1;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						record_count_q <= rcount_inc;
						if (split)
							n_q <= n_q + 1'b1;
						else
							state_q <= S_IDLE;
					end
				end
				S_END: begin
					if (out_free) begin
						state_q        <= S_IDLE;
						prev_x_q       <= '0;
						prev_y_q       <= '0;
						min_x_q        <= '0;
						max_x_q        <= '0;
						min_y_q        <= '0;
						max_y_q        <= '0;
						record_count_q <= '0;
						color_count_q  <= '0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_xfer) begin
			dx_q  <= DW'(stitch.pos_x) - DW'(prev_x_q);
			dy_q  <= DW'(stitch.pos_y) - DW'(prev_y_q);
			jmp_q <= stitch.jump;
			col_q <= stitch.color_change;
		end else if (state_q == S_EMIT && out_free && split) begin
			dx_q <= dx_q - sx_w;
			dy_q <= dy_q - sy_w;
		end

		if (state_q == S_EMIT && out_free) begin
			b0_q      <= enc_b0;
			b1_q      <= enc_b1;
			b2_q      <= enc_b2;
			last_q    <= !split;
			rtot_q    <= '0;
			ctot_q    <= '0;
			plus_x_q  <= '0;
			minus_x_q <= '0;
			plus_y_q  <= '0;
			minus_y_q <= '0;
		end else if (state_q == S_END && out_free) begin
			b0_q      <= 8'h00;
			b1_q      <= 8'h00;
			b2_q      <= END_B2;
			last_q    <= 1'b1;
			rtot_q    <= rcount_inc;
			ctot_q    <= color_count_q;
			plus_x_q  <= max_x_q[COORD_BITS-2:0];
			plus_y_q  <= max_y_q[COORD_BITS-2:0];
			minus_x_q <= COORD_BITS'(0) - min_x_q;
			minus_y_q <= COORD_BITS'(0) - min_y_q;
		end
	end

	assign rec.valid        = valid_q;
	assign rec.rec_b0       = b0_q;
	assign rec.rec_b1       = b1_q;
	assign rec.rec_b2       = b2_q;
	assign rec.last         = last_q;
	assign rec.record_total = rtot_q;
	assign rec.color_total  = ctot_q;
	assign rec.plus_x       = plus_x_q;
	assign rec.minus_x      = minus_x_q;
	assign rec.plus_y       = plus_y_q;
	assign rec.minus_y      = minus_y_q;

`ifndef SYNTHESIS
	a_nrec_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NLAST)
		else $error("split record count past limit");

	a_stitch_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && stitch.operation == OP_STITCH) |=> (state_q == S_EMIT))
		else $error("stitch transfer did not start emission");

	a_final_rec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free && !split) |=> (state_q == S_IDLE && rec.valid
		&& rec.last))
		else $error("final record of a move not marked last");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_END && out_free) |=> (record_count_q == '0 && color_count_q == '0
		&& rec.rec_b2 == END_B2))
		else $error("end record did not clear statistics");
`endif

endmodule

[verif/tb_top.sv]
module tb_top import dsten_pkg::*; ();

	localparam int COORD_BITS = DEF_COORD_BITS;
	localparam int MAX_STEP   = DEF_MAX_STEP;
	localparam int XMIN       = -(1 << (COORD_BITS - 1));
	localparam int XMAX       = (1 << (COORD_BITS - 1)) - 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [7:0]            b0;
		logic [7:0]            b1;
		logic [7:0]            b2;
		logic                  last;
		logic [RTOT_BITS-1:0]  rtot;
		logic [CTOT_BITS-1:0]  ctot;
		logic [COORD_BITS-2:0] px;
		logic [COORD_BITS-1:0] mx;
		logic [COORD_BITS-2:0] py;
		logic [COORD_BITS-1:0] my;
	} dst_rec_t;

	logic clk;
	logic arst_n;

	dsten_in_if  #(.COORD_BITS(COORD_BITS)) stitch_if ();
	dsten_out_if #(.COORD_BITS(COORD_BITS)) rec_if ();

	dst_stitch_stream_encoder #(
		.MAX_STEP   (MAX_STEP),
		.COORD_BITS (COORD_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stitch (stitch_if),
		.rec    (rec_if)
	);

	// encoder state as seen from the stream
	int                   last_x, last_y;
	int                   lo_x, hi_x, lo_y, hi_y;
	logic [RTOT_BITS-1:0] rec_count;
	logic [CTOT_BITS-1:0] color_count;

	dst_rec_t expected_records[$];

	int err_count;
	int items_sent;
	int records_seen;
	int designs_closed;
	int split_moves;
	int gap_pct;
	int stall_pct;
	int stall_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int clamp_step(input int v);
		if (v > MAX_STEP)
			return MAX_STEP;
		if (v < -MAX_STEP)
			return -MAX_STEP;
		return v;
	endfunction

	// balanced ternary, weights 81 27 9 3 1; byte order b0 b1 b2
	function automatic logic [23:0] dst_triplet(input int dx, input int dy,
			input logic jmp, input logic col);
		logic [7:0] b [3];
		int w, half;
		logic [1:0] sel;
		b[0] = 8'h00;
		b[1] = 8'h00;
		b[2] = BASE_B2;
		if (jmp)
			b[2] |= JUMP_BIT;
		if (col)
			b[2] |= COLOR_BIT;
		w = 81;
		for (int i = 0; i < 5; i++) begin
			half = (w - 1) / 2;
			sel  = (i == 0) ? 2'd2 : ((i == 1 || i == 3) ? 2'd1 : 2'd0);
			if (dx > half) begin
				b[sel] |= (i < 3) ? 8'h04 : 8'h01;
				dx -= w;
			end else if (dx < -half) begin
				b[sel] |= (i < 3) ? 8'h08 : 8'h02;
				dx += w;
			end
			if (dy > half) begin
				b[sel] |= (i < 3) ? 8'h20 : 8'h80;
				dy -= w;
			end else if (dy < -half) begin
				b[sel] |= (i < 3) ? 8'h10 : 8'h40;
				dy += w;
			end
			w = w / 3;
		end
		return {b[0], b[1], b[2]};
	endfunction

	task automatic bump_records();
		if (rec_count < REC_LIMIT)
			rec_count++;
	endtask

	task automatic clear_design();
		last_x      = 0;
		last_y      = 0;
		lo_x        = 0;
		hi_x        = 0;
		lo_y        = 0;
		hi_y        = 0;
		rec_count   = '0;
		color_count = '0;
	endtask

	// queue the DST records one accepted item must produce
	task automatic predict_records(input logic op, input coord_t x, input coord_t y,
			input logic jmp, input logic col);
		dst_rec_t r;
		int dx, dy, sx, sy, n;
		r = '0;
		if (op == OP_FINISH) begin
			bump_records();
			r.b2   = END_B2;
			r.last = 1'b1;
			r.rtot = rec_count;
			r.ctot = color_count;
			r.px   = (COORD_BITS-1)'((hi_x > 0) ? hi_x : 0);
			r.mx   = COORD_BITS'((lo_x < 0) ? -lo_x : 0);
			r.py   = (COORD_BITS-1)'((hi_y > 0) ? hi_y : 0);
			r.my   = COORD_BITS'((lo_y < 0) ? -lo_y : 0);
			expected_records.push_back(r);
			clear_design();
			designs_closed++;
			return;
		end
		dx = int'(x) - last_x;
		dy = int'(y) - last_y;
		if (int'(x) < lo_x) lo_x = int'(x);
		if (int'(x) > hi_x) hi_x = int'(x);
		if (int'(y) < lo_y) lo_y = int'(y);
		if (int'(y) > hi_y) hi_y = int'(y);
		if (col && color_count < COLOR_LIMIT)
			color_count++;
		n = 0;
		if (dx > MAX_STEP || dx < -MAX_STEP || dy > MAX_STEP || dy < -MAX_STEP)
			split_moves++;
		while ((dx > MAX_STEP || dx < -MAX_STEP || dy > MAX_STEP || dy < -MAX_STEP)
				&& n < MAX_RESULTS - 1) begin
			sx = clamp_step(dx);
			sy = clamp_step(dy);
			r = '0;
			{r.b0, r.b1, r.b2} = dst_triplet(sx, sy, 1'b1, 1'b0);
			expected_records.push_back(r);
			bump_records();
			n++;
			dx -= sx;
			dy -= sy;
		end
		r = '0;
		{r.b0, r.b1, r.b2} = dst_triplet(clamp_step(dx), clamp_step(dy), jmp, col);
		r.last = 1'b1;
		expected_records.push_back(r);
		bump_records();
		last_x = int'(x);
		last_y = int'(y);
	endtask

	task automatic send_item(input logic op, input coord_t x, input coord_t y,
			input logic jmp, input logic col);
		int gap;
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				stitch_if.valid        <= 1'b0;
				stitch_if.operation    <= 1'($urandom);
				stitch_if.pos_x        <= coord_t'($urandom);
				stitch_if.pos_y        <= coord_t'($urandom);
				stitch_if.jump         <= 1'($urandom);
				stitch_if.color_change <= 1'($urandom);
			end
		end
		@(negedge clk);
		stitch_if.valid        <= 1'b1;
		stitch_if.operation    <= op;
		stitch_if.pos_x        <= x;
		stitch_if.pos_y        <= y;
		stitch_if.jump         <= jmp;
		stitch_if.color_change <= col;
		do
			@(posedge clk);
		while (!stitch_if.ready);
		items_sent++;
		predict_records(op, x, y, jmp, col);
	endtask

	task automatic sender_idle();
		@(negedge clk);
		stitch_if.valid <= 1'b0;
	endtask

	task automatic drain_results();
		sender_idle();
		while (expected_records.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			err_count++;
		end
	endtask

	// output side: random stall bursts on ready
	initial begin
		rec_if.ready = 1'b0;
		stall_left   = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rec_if.ready <= 1'b0;
				stall_left--;
			end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 5);
				rec_if.ready <= 1'b0;
			end else begin
				rec_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		dst_rec_t e;
		if (arst_n && rec_if.valid && rec_if.ready) begin
			records_seen++;
			if (expected_records.size() == 0) begin
				$error("record transfer with nothing expected: %h %h %h",
					rec_if.rec_b0, rec_if.rec_b1, rec_if.rec_b2);
				err_count++;
			end else begin
				e = expected_records.pop_front();
				check_field("rec_b0", e.b0, rec_if.rec_b0);
				check_field("rec_b1", e.b1, rec_if.rec_b1);
				check_field("rec_b2", e.b2, rec_if.rec_b2);
				check_field("last", e.last, rec_if.last);
				check_field("record_total", e.rtot, rec_if.record_total);
				check_field("color_total", e.ctot, rec_if.color_total);
				check_field("plus_x", e.px, rec_if.plus_x);
				check_field("minus_x", e.mx, rec_if.minus_x);
				check_field("plus_y", e.py, rec_if.plus_y);
				check_field("minus_y", e.my, rec_if.minus_y);
			end
		end
	end

	task automatic test_empty_finish();
		send_item(OP_FINISH, '0, '0, 1'b0, 1'b0);
		send_item(OP_FINISH, coord_t'(XMAX), coord_t'(XMIN), 1'b1, 1'b1);
	endtask

	// one digit at a time, exact step limit, just past it, corner to corner
	task automatic test_directed_moves();
		send_item(OP_STITCH, 0, 0, 1'b0, 1'b0);
		send_item(OP_STITCH, 1, -1, 1'b0, 1'b0);
		send_item(OP_STITCH, 5, -5, 1'b0, 1'b0);
		send_item(OP_STITCH, 18, -18, 1'b0, 1'b0);
		send_item(OP_STITCH, 58, -58, 1'b0, 1'b0);
		send_item(OP_STITCH, 99, -99, 1'b0, 1'b0);
		send_item(OP_STITCH, 220, -220, 1'b1, 1'b0);
		send_item(OP_STITCH, 99, -99, 1'b0, 1'b1);
		send_item(OP_STITCH, 221, -221, 1'b1, 1'b1);
		send_item(OP_STITCH, -3, 40, 1'b0, 1'b0);
		send_item(OP_STITCH, coord_t'(XMAX), coord_t'(XMAX), 1'b0, 1'b0);
		send_item(OP_STITCH, coord_t'(XMIN), coord_t'(XMIN), 1'b0, 1'b1);
		send_item(OP_STITCH, coord_t'(XMIN), coord_t'(XMAX), 1'b1, 1'b0);
		send_item(OP_STITCH, 0, 0, 1'b1, 1'b0);
		send_item(OP_FINISH, '0, '0, 1'b0, 1'b0);
		// after a finish the next move starts from the origin again
		send_item(OP_STITCH, -5, 7, 1'b0, 1'b0);
		send_item(OP_STITCH, -130, 7, 1'b0, 1'b0);
		send_item(OP_FINISH, '0, '0, 1'b0, 1'b0);
	endtask

	// a run of color changes counted into one design
	task automatic test_color_changes();
		for (int i = 0; i < 40; i++)
			send_item(OP_STITCH, coord_t'(i & 1), coord_t'(-(i & 1)), 1'b0, 1'b1);
		send_item(OP_FINISH, '0, '0, 1'b0, 1'b0);
		drain_results();
	endtask

	task automatic test_random_designs(input int count);
		int r, nx, ny;
		logic jmp, col;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 15;
					default: gap_pct = 40;
				endcase
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 40;
				endcase
			end
			// quiet tail
			if (i >= count - 90) begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			if (i == count / 2)
				drain_results();
			r   = $urandom_range(0, 99);
			jmp = ($urandom_range(0, 99) < 15);
			col = ($urandom_range(0, 99) < 10);
			if (r < 5) begin
				send_item(OP_FINISH, coord_t'($urandom), coord_t'($urandom),
					1'($urandom), 1'($urandom));
			end else if (r < 13) begin
				nx = int'(coord_t'($urandom));
				ny = int'(coord_t'($urandom));
				if ($urandom_range(0, 3) == 0)
					nx = $urandom_range(0, 1) ? XMAX : XMIN;
				if ($urandom_range(0, 3) == 0)
					ny = $urandom_range(0, 1) ? XMAX : XMIN;
				send_item(OP_STITCH, coord_t'(nx), coord_t'(ny), jmp, col);
			end else begin
				if (r < 22) begin
					nx = last_x + int'($urandom_range(0, 300)) - 150;
					ny = last_y + int'($urandom_range(0, 300)) - 150;
				end else begin
					nx = last_x + int'($urandom_range(0, 2 * MAX_STEP)) - MAX_STEP;
					ny = last_y + int'($urandom_range(0, 2 * MAX_STEP)) - MAX_STEP;
				end
				nx = (nx > XMAX) ? XMAX : ((nx < XMIN) ? XMIN : nx);
				ny = (ny > XMAX) ? XMAX : ((ny < XMIN) ? XMIN : ny);
				send_item(OP_STITCH, coord_t'(nx), coord_t'(ny), jmp, col);
			end
		end
		send_item(OP_FINISH, '0, '0, 1'b0, 1'b0);
	endtask

	initial begin
		arst_n                 = 1'b0;
		stitch_if.valid        = 1'b0;
		stitch_if.operation    = OP_STITCH;
		stitch_if.pos_x        = '0;
		stitch_if.pos_y        = '0;
		stitch_if.jump         = 1'b0;
		stitch_if.color_change = 1'b0;
		err_count      = 0;
		items_sent     = 0;
		records_seen   = 0;
		designs_closed = 0;
		split_moves    = 0;
		gap_pct        = 20;
		stall_pct      = 20;
		clear_design();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_finish();
		test_directed_moves();
		test_color_changes();
		test_random_designs(408);

		sender_idle();
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d items, %0d records, %0d finished designs, %0d split moves",
			items_sent, records_seen, designs_closed, split_moves);
		$display("color change counting, full-range corner moves and empty designs included");
		if (err_count == 0)
			$display("dst_stitch_stream_encoder test passed");
		else
			$display("dst_stitch_stream_encoder test failed");
		$finish;
	end

	initial begin
		#10000000;
		$display("timeout with %0d records still expected", expected_records.size());
		$display("dst_stitch_stream_encoder test failed");
		$finish;
	end

endmodule

[files.f]
rtl/core/dsten_pkg.sv
rtl/core/dsten_in_if.sv
rtl/core/dsten_out_if.sv
rtl/core/dsten_enc.sv
rtl/core/dst_stitch_stream_encoder.sv
verif/tb_top.sv
